FILE: hw/rtl/bilinear_bayer_demosaic_top_macros.svh
// Assertion macros for the bilinear Bayer demosaic block.
`ifndef BILINEAR_BAYER_DEMOSAIC_TOP_MACROS_SVH
`define BILINEAR_BAYER_DEMOSAIC_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBD_ASSERT_IMM(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbd: next-cycle check failed");

`endif

FILE: hw/rtl/bbd_pkg.sv
// Package: constants and types shared by the bilinear Bayer demosaic modules.
`default_nettype none
package bbd_pkg;
    localparam int MAX_WIDTH  = 4096;
    localparam int PIX_W      = 8;
    localparam int DIM_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int W_W        = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int ROW_W      = DIM_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = PIX_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    // Position and sample of one item, decoded at acceptance.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             emit;
        logic             ocol_first;
        logic             ocol_last;
        logic             orow_first;
        logic             orow_last;
        logic             orow_odd;
        logic             ocol_odd;
        logic             last;
    } t_pos;

    typedef struct packed {
        logic busy;
        logic commit;
        logic emit;
    } t_status;

    // Write-back to both line buffers.
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } t_wr;
endpackage
`default_nettype wire

FILE: hw/rtl/bbd_in_if.sv
// Interface: raw Bayer input channel.
`default_nettype none
interface bbd_in_if import bbd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] raw_pixel;
    logic             flush_item;

    modport source (output valid, output raw_pixel, output flush_item, input ready);
    modport sink   (input valid, input raw_pixel, input flush_item, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bbd_out_if.sv
// Interface: RGB result channel.
`default_nettype none
interface bbd_out_if import bbd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_last;

    modport source (output valid, output red, output green, output blue,
                    output frame_last, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bbd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/bbd_ctrl.sv
// Configuration registers, frame position counters and position decode.
`default_nettype none
module bbd_ctrl import bbd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic                 i_acc,
    input  wire logic [PIX_W-1:0]     i_raw_pixel,
    input  wire logic                 i_flush_item,
    output t_pos                      o_pos,
    output logic                      o_take
);
    logic [DIM_W-1:0] r_width, r_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [W_W-1:0]   w, wr, c_inc;
    logic [DIM_W-1:0] h;
    logic [ROW_W-1:0] h1, hm1, r0, orow;
    logic [COL_W-1:0] c0, ocol;
    logic             body, ignore;

    always_comb begin
        wr = W_W'(r_width);
        if (wr < W_W'(2)) begin
            w = W_W'(2);
        end else if (wr > W_W'(MAX_WIDTH)) begin
            w = W_W'(MAX_WIDTH);
        end else begin
            w = wr;
        end
        h   = (r_height < DIM_W'(2)) ? DIM_W'(2) : r_height;
        h1  = ROW_W'(h) + ROW_W'(1);
        hm1 = ROW_W'(h) - ROW_W'(1);

        // bring the counters back inside the frame
        c0 = r_col;
        r0 = r_row;
        if (W_W'(r_col) >= w) begin
            c0 = '0;
            r0 = r_row + ROW_W'(1);
        end
        if (r0 > h1 || (r0 == h1 && c0 != '0)) begin
            r0 = '0;
            c0 = '0;
        end
        body   = r0 < ROW_W'(h);
        ignore = body && i_flush_item;

        c_inc = W_W'(c0) + W_W'(1);
        if (ignore) begin
            n_col = c0;
            n_row = r0;
        end else if (r0 == h1) begin
            n_col = '0;
            n_row = '0;
        end else if (c_inc >= w) begin
            n_col = '0;
            n_row = r0 + ROW_W'(1);
        end else begin
            n_col = c_inc[COL_W-1:0];
            n_row = r0;
        end

        // output pixel is one row and one column behind
        if (c0 != '0) begin
            o_pos.emit = r0 >= ROW_W'(1);
            orow       = r0 - ROW_W'(1);
            ocol       = c0 - COL_W'(1);
        end else begin
            o_pos.emit = r0 >= ROW_W'(2);
            orow       = r0 - ROW_W'(2);
            ocol       = COL_W'(w - W_W'(1));
        end
        o_pos.col        = c0;
        o_pos.pix        = body ? i_raw_pixel : '0;
        o_pos.ocol_first = ocol == '0;
        o_pos.ocol_last  = W_W'(ocol) == (w - W_W'(1));
        o_pos.orow_first = orow == '0;
        o_pos.orow_last  = orow == hm1;
        o_pos.orow_odd   = orow[0];
        o_pos.ocol_odd   = ocol[0];
        o_pos.last       = o_pos.orow_last && o_pos.ocol_last;
        o_take           = i_acc && !ignore;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/bbd_interp.sv
// Window stage: 3x3 window update, border mirroring, interpolation, output register.
`default_nettype none
module bbd_interp import bbd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire t_pos             i_pos,
    input  wire logic [PIX_W-1:0] i_rd_upper,
    input  wire logic [PIX_W-1:0] i_rd_middle,
    output t_status               o_status,
    output t_wr                   o_wr,
    bbd_out_if.source             o_rgb
);
    logic             r_s1_v;
    t_pos             r_s1;
    logic [PIX_W-1:0] r_win [0:2][0:2];
    logic [PIX_W-1:0] n_win [0:2][0:2];
    logic [PIX_W-1:0] v     [0:2][0:2];
    logic             commit;

    logic             r_o_valid, r_last;
    logic [PIX_W-1:0] r_red, r_green, r_blue;
    logic [PIX_W-1:0] n_red, n_green, n_blue;
    logic [SUM_W-1:0] s_h, s_v, s_x, s_d;

    assign commit = r_s1_v && (!r_s1.emit || !r_o_valid || o_rgb.ready);

    always_comb begin
        for (int y = 0; y < 3; y++) begin
            n_win[y][0] = r_win[y][1];
            n_win[y][1] = r_win[y][2];
        end
        n_win[0][2] = i_rd_upper;
        n_win[1][2] = i_rd_middle;
        n_win[2][2] = r_s1.pix;

        v = n_win;
        if (r_s1.ocol_first) begin
            for (int y = 0; y < 3; y++) v[y][0] = v[y][2];
        end
        if (r_s1.ocol_last) begin
            for (int y = 0; y < 3; y++) v[y][2] = v[y][0];
        end
        if (r_s1.orow_first) begin
            for (int x = 0; x < 3; x++) v[0][x] = v[2][x];
        end
        if (r_s1.orow_last) begin
            for (int x = 0; x < 3; x++) v[2][x] = v[0][x];
        end

        s_h = SUM_W'(v[1][0]) + SUM_W'(v[1][2]);
        s_v = SUM_W'(v[0][1]) + SUM_W'(v[2][1]);
        s_x = s_h + s_v;
        s_d = SUM_W'(v[0][0]) + SUM_W'(v[0][2]) + SUM_W'(v[2][0]) + SUM_W'(v[2][2]);

        case ({r_s1.orow_odd, r_s1.ocol_odd})
            2'b00: begin  // green on a red row
                n_green = v[1][1];
                n_red   = s_h[PIX_W:1];
                n_blue  = s_v[PIX_W:1];
            end
            2'b01: begin  // red
                n_red   = v[1][1];
                n_green = s_x[PIX_W+1:2];
                n_blue  = s_d[PIX_W+1:2];
            end
            2'b10: begin  // blue
                n_blue  = v[1][1];
                n_green = s_x[PIX_W+1:2];
                n_red   = s_d[PIX_W+1:2];
            end
            default: begin  // green on a blue row
                n_green = v[1][1];
                n_blue  = s_h[PIX_W:1];
                n_red   = s_v[PIX_W:1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (commit || !r_s1_v) begin
            r_s1_v <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1 <= i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int y = 0; y < 3; y++)
                for (int x = 0; x < 3; x++) r_win[y][x] <= '0;
        end else if (commit) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (commit && r_s1.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && r_s1.emit) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_last  <= r_s1.last;
        end
    end

    assign o_rgb.valid      = r_o_valid;
    assign o_rgb.red        = r_red;
    assign o_rgb.green      = r_green;
    assign o_rgb.blue       = r_blue;
    assign o_rgb.frame_last = r_last;

    assign o_status.busy   = r_s1_v;
    assign o_status.commit = commit;
    assign o_status.emit   = r_s1.emit;

    // the upper line takes the old middle row, the middle line the new sample
    assign o_wr.en     = commit;
    assign o_wr.addr   = r_s1.col;
    assign o_wr.upper  = i_rd_middle;
    assign o_wr.middle = r_s1.pix;
endmodule
`default_nettype wire

FILE: hw/rtl/bilinear_bayer_demosaic_top.sv
// Top level of the bilinear GRBG Bayer demosaic block.
//
// Raw GRBG samples enter in raster order on i_pix (valid/ready); each accepted
// sample yields one RGB pixel on o_rgb, with frame_last on the bottom-right
// pixel. Missing colours are truncated means of 2 or 4 same-colour
// neighbours, borders mirrored. The output runs one row plus one pixel behind
// the input: after the last sample of a frame send frame_width + 1 items with
// flush_item set. A flush item inside the frame body is dropped.
// Throughput is one item per cycle unless o_rgb stalls, set by the single read
// and write port of each line buffer (two 4096 x 8 RAMs, read at acceptance,
// written back as the window stage commits). Write frame_width and
// frame_height on the i_cfg port only while idle; the block does not enforce
// it. Reset restores 640 x 480 and clears the counters and window; the line
// buffers are not cleared, since unwritten entries are always mirrored away.
// When o_rgb stalls, the result is held, one more item waits in the window
// stage and i_pix.ready then drops until the receiver takes the result.
`default_nettype none
`include "bilinear_bayer_demosaic_top_macros.svh"
module bilinear_bayer_demosaic_top import bbd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    bbd_in_if.sink                    i_pix,
    bbd_out_if.source                 o_rgb
);
    t_pos             pos;
    t_status          st;
    t_wr              wr;
    logic             take, acc;
    logic [PIX_W-1:0] rd_upper, rd_middle;

    assign i_pix.ready = !st.busy || st.commit;
    assign acc         = i_pix.valid && i_pix.ready;

    bbd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_acc        (acc),
        .i_raw_pixel  (i_pix.raw_pixel),
        .i_flush_item (i_pix.flush_item),
        .o_pos        (pos),
        .o_take       (take)
    );

    bbd_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.upper),
        .i_re    (take),
        .i_raddr (pos.col),
        .o_rdata (rd_upper)
    );

    bbd_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.middle),
        .i_re    (take),
        .i_raddr (pos.col),
        .o_rdata (rd_middle)
    );

    bbd_interp u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_pos       (pos),
        .i_rd_upper  (rd_upper),
        .i_rd_middle (rd_middle),
        .o_status    (st),
        .o_wr        (wr),
        .o_rgb       (o_rgb)
    );

    `BBD_ASSERT_IMM(a_stall_blocks_input, i_clk, i_rst_n, st.busy && !st.commit, !i_pix.ready)
    `BBD_ASSERT_IMM(a_no_result_overwrite, i_clk, i_rst_n, st.commit && st.emit, !o_rgb.valid || o_rgb.ready)
    `BBD_ASSERT_NXT(a_result_registered, i_clk, i_rst_n, st.commit && st.emit, o_rgb.valid)
    `BBD_ASSERT_NXT(a_take_fills_stage, i_clk, i_rst_n, take, st.busy)
endmodule
`default_nettype wire
